[hw/rtl/mqr_pkg.sv]
// shared types, codes and constants for the quarter-turn matrix rotator
package mqr_pkg;

  localparam int unsigned DIM_W   = 4;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TURN_W  = 2;

  // configuration register indexes
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_TURNS = 2'd2;

  // quarter-turn codes
  localparam logic [TURN_W-1:0] TURN_0 = 2'd0;
  localparam logic [TURN_W-1:0] TURN_1 = 2'd1;
  localparam logic [TURN_W-1:0] TURN_2 = 2'd2;
  localparam logic [TURN_W-1:0] TURN_3 = 2'd3;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } mqr_state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] element_value;
  } mqr_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     row_end;
    logic                     last;
  } mqr_out_t;

  // position tags that travel alongside a store read
  typedef struct packed {
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
    logic             row_end;
    logic             last;
  } mqr_meta_t;

endpackage

[hw/rtl/mqr_stream_if.sv]
// valid/ready stream channel carrying one word of a given payload type
interface mqr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/matrix_quarter_turn_rotator_top.sv]
// Matrix quarter-turn rotator top level: config registers, store, sequencer, result queue
// Loading takes one cycle per word; ready stays high until the last element is taken.
// The first rotated word is valid once its store read has issued and the registered
// data has entered the result queue, then one word per cycle while the sink is ready
// (one store read port per cycle); the next load begins only after the last read issues.
// Reset: rows = cols = 8, quarter_turns = 0, element count cleared; the store is not cleared.
module matrix_quarter_turn_rotator_top #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [mqr_pkg::DIM_W-1:0]  cfg_data,
  mqr_stream_if.sink                 elem_in,
  mqr_stream_if.source               rot_out
);
  import mqr_pkg::*;

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DIM_W-1:0]  rows, cols;
  logic [TURN_W-1:0] quarter_turns;
  logic              wr_en, issue, can_issue;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] rd_data;
  mqr_meta_t         meta;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows          <= DIM_W'(8);
      cols          <= DIM_W'(8);
      quarter_turns <= TURN_0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROWS:  rows          <= cfg_data;
        REG_COLS:  cols          <= cfg_data;
        REG_TURNS: quarter_turns <= cfg_data[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  // matrix store
  mqr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(elem_in.payload.element_value),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // load counter and emission sequencer
  mqr_seq #(
    .MAX_DIM(MAX_DIM),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .rows     (rows),
    .cols     (cols),
    .turns    (quarter_turns),
    .in_valid (elem_in.valid),
    .in_ready (elem_in.ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .can_issue(can_issue),
    .issue    (issue),
    .rd_addr  (rd_addr),
    .meta     (meta)
  );

  // result queue
  mqr_oq u_oq (
    .clk      (clk),
    .rst      (rst),
    .issue    (issue),
    .meta     (meta),
    .rd_data  (rd_data),
    .can_issue(can_issue),
    .rot_out  (rot_out)
  );

endmodule

[hw/rtl/mqr_ram.sv]
// generic single-write, single-read ram with registered read data
module mqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[hw/rtl/mqr_seq.sv]
// load counter and emission sequencer with the read address unit
module mqr_seq #(
  parameter int unsigned MAX_DIM = 8,
  parameter int unsigned ADDR_W = 6
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mqr_pkg::DIM_W-1:0]  rows,
  input  logic [mqr_pkg::DIM_W-1:0]  cols,
  input  logic [mqr_pkg::TURN_W-1:0] turns,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       wr_en,
  output logic [ADDR_W-1:0]          wr_addr,
  input  logic                       can_issue,
  output logic                       issue,
  output logic [ADDR_W-1:0]          rd_addr,
  output mqr_pkg::mqr_meta_t         meta
);
  import mqr_pkg::*;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

  mqr_state_t          state, state_next;
  logic [COUNT_W-1:0]  load_count, load_count_next;
  logic [DIM_W-1:0]    nr, nc;
  logic [TURN_W-1:0]   turns_q;
  logic [IDX_W-1:0]    r, c, r_next, c_next;
  logic [DIM_W-1:0]    nr_cfg, nc_cfg;
  logic [2*DIM_W-1:0]  total_cfg;
  logic [COUNT_W-1:0]  count_inc;
  logic                accept, complete;
  logic [DIM_W-1:0]    orows, ocols;
  logic                r_last, c_last;
  logic [DIM_W-1:0]    src_i, src_j;
  logic [COUNT_W-1:0]  src_addr;

  // clamp configured dimensions into 1..MAX_DIM
  always_comb begin
    nr_cfg = rows;
    if (rows == '0) begin
      nr_cfg = DIM_ONE;
    end else if (rows > DIM_MAX) begin
      nr_cfg = DIM_MAX;
    end
    nc_cfg = cols;
    if (cols == '0) begin
      nc_cfg = DIM_ONE;
    end else if (cols > DIM_MAX) begin
      nc_cfg = DIM_MAX;
    end
  end

  // element count check
  assign total_cfg = nr_cfg * nc_cfg;
  assign count_inc = load_count + COUNT_W'(1);
  assign accept    = in_valid && (state == ST_LOAD);
  assign complete  = {1'b0, count_inc} >= total_cfg;

  // turned matrix shape and position flags
  assign orows  = turns_q[0] ? nc : nr;
  assign ocols  = turns_q[0] ? nr : nc;
  assign r_last = ({1'b0, r} == (orows - DIM_ONE));
  assign c_last = ({1'b0, c} == (ocols - DIM_ONE));

  // source coordinate in the stored matrix
  always_comb begin
    case (turns_q)
      TURN_1: begin
        src_i = nr - DIM_ONE - {1'b0, c};
        src_j = {1'b0, r};
      end
      TURN_2: begin
        src_i = nr - DIM_ONE - {1'b0, r};
        src_j = nc - DIM_ONE - {1'b0, c};
      end
      TURN_3: begin
        src_i = {1'b0, c};
        src_j = nc - DIM_ONE - {1'b0, r};
      end
      default: begin
        src_i = {1'b0, r};
        src_j = {1'b0, c};
      end
    endcase
  end

  // row-major store address, stride nc
  assign src_addr = (COUNT_W'(src_i) * COUNT_W'(nc)) + COUNT_W'(src_j);
  assign rd_addr  = src_addr[ADDR_W-1:0];

  assign wr_addr = load_count[ADDR_W-1:0];
  assign meta    = '{out_row: r, out_col: c, row_end: c_last, last: r_last && c_last};

  // next state and outputs
  always_comb begin
    state_next      = state;
    load_count_next = load_count;
    r_next          = r;
    c_next          = c;
    in_ready        = 1'b0;
    wr_en           = 1'b0;
    issue           = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        wr_en    = in_valid;
        if (accept) begin
          if (complete) begin
            load_count_next = '0;
            r_next          = '0;
            c_next          = '0;
            state_next      = ST_EMIT;
          end else begin
            load_count_next = count_inc;
          end
        end
      end
      ST_EMIT: begin
        issue = can_issue;
        if (can_issue) begin
          if (c_last) begin
            c_next = '0;
            r_next = r + IDX_W'(1);
            if (r_last) begin
              state_next = ST_LOAD;
            end
          end else begin
            c_next = c + IDX_W'(1);
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
    end else begin
      state      <= state_next;
      load_count <= load_count_next;
    end
  end

  // emission counters and shape latched when the matrix completes
  always_ff @(posedge clk) begin
    r <= r_next;
    c <= c_next;
    if (accept && complete) begin
      nr      <= nr_cfg;
      nc      <= nc_cfg;
      turns_q <= turns;
    end
  end

  a_no_issue_while_loading: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !issue)
    else $error("store read issued while accepting words");

  a_last_returns_to_load: assert property (@(posedge clk) disable iff (rst)
    (issue && meta.last) |=> (state == ST_LOAD) && (load_count == '0))
    else $error("sequencer did not return to loading after the last read");

  a_complete_starts_at_origin: assert property (@(posedge clk) disable iff (rst)
    (accept && complete) |=> (state == ST_EMIT) && (r == '0) && (c == '0))
    else $error("emission did not start at the first position");

endmodule

[hw/rtl/mqr_oq.sv]
// two-entry result queue fed by the store read port
module mqr_oq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         issue,
  input  mqr_pkg::mqr_meta_t           meta,
  input  logic [mqr_pkg::DATA_W-1:0]   rd_data,
  output logic                         can_issue,
  mqr_stream_if.source                 rot_out
);
  import mqr_pkg::*;

  mqr_out_t  slots [2];
  mqr_meta_t meta_q;
  logic      inflight;
  logic      wr_ptr, rd_ptr;
  logic [1:0] occ;
  logic      push, pop;

  assign push = inflight;
  assign pop  = rot_out.valid && rot_out.ready;

  // room for one more read counting the word already in flight
  assign can_issue = ({1'b0, occ} + {2'b00, inflight}) < (3'd2 + {2'b00, pop});

  assign rot_out.valid   = (occ != 2'd0);
  assign rot_out.payload = slots[rd_ptr];

  // control: in-flight flag, pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      occ      <= 2'd0;
    end else begin
      inflight <= issue;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      occ <= occ + {1'b0, push} - {1'b0, pop};
    end
  end

  // payload: tags are registered at the read, in step with the store read data
  always_ff @(posedge clk) begin
    if (issue) begin
      meta_q <= meta;
    end
    if (push) begin
      slots[wr_ptr] <= '{value: rd_data, out_row: meta_q.out_row, out_col: meta_q.out_col,
                         row_end: meta_q.row_end, last: meta_q.last};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (occ != 2'd2) || pop)
    else $error("result queue overflow");

endmodule
